// ===== src/repeating_task_timer_macros.svh =====
// ---------------------------------------------------------------------------
// Repeating task timer assertion macros
// Concurrent assertion shorthands on clk, with and without the reset guard.
// ---------------------------------------------------------------------------
`ifndef REPEATING_TASK_TIMER_MACROS_SVH
`define REPEATING_TASK_TIMER_MACROS_SVH

// checked only outside reset
`define RTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rtt_pkg.sv =====
// ---------------------------------------------------------------------------
// Repeating task timer package
// Widths, codes and shared types of the repeating task timer.
// ---------------------------------------------------------------------------
package rtt_pkg;

  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 16;
  localparam int CFG_DATA_W = (TIME_W > COUNT_W) ? TIME_W : COUNT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int EV_W       = 2;
  localparam int OS_W       = 3;
  localparam int NRES       = 3;
  localparam int RCNT_W     = 2;

  localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
  localparam logic [EV_W-1:0] EV_START = 2'd1;
  localparam logic [EV_W-1:0] EV_MAIN  = 2'd2;
  localparam logic [EV_W-1:0] EV_END   = 2'd3;

  localparam logic [OS_W-1:0] OS_NONE = 3'd0;
  localparam logic [OS_W-1:0] OS_S    = 3'd1;
  localparam logic [OS_W-1:0] OS_C    = 3'd2;
  localparam logic [OS_W-1:0] OS_SC   = 3'd3;
  localparam logic [OS_W-1:0] OS_SCE  = 3'd4;
  localparam logic [OS_W-1:0] OS_SE   = 3'd5;
  localparam logic [OS_W-1:0] OS_CE   = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_TIME    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_FINAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONESHOT     = 3'd5;

  typedef struct packed {
    logic [TIME_W-1:0]  period;
    logic [TIME_W-1:0]  start_delay;
    logic [TIME_W-1:0]  end_time;
    logic [COUNT_W-1:0] repeat_max;
    logic               extra_final_period;
    logic [OS_W-1:0]    oneshot_mode;
  } cfg_t;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] now;
    logic              start_enable;
  } item_t;

  typedef struct packed {
    logic [RCNT_W-1:0]          cnt;
    logic [NRES-1:0][EV_W-1:0]  evs;
  } res_t;

endpackage

// ===== src/rtt_cfg.sv =====
// ---------------------------------------------------------------------------
// Repeating task timer configuration registers
// Register file written by index over the configuration channel.
// ---------------------------------------------------------------------------
module rtt_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rtt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtt_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rtt_pkg::cfg_t                    cfg
);

  rtt_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        rtt_pkg::CFG_PERIOD:      cfg_r.period <= cfg_data[rtt_pkg::TIME_W-1:0];
        rtt_pkg::CFG_START_DELAY: cfg_r.start_delay <= cfg_data[rtt_pkg::TIME_W-1:0];
        rtt_pkg::CFG_END_TIME:    cfg_r.end_time <= cfg_data[rtt_pkg::TIME_W-1:0];
        rtt_pkg::CFG_REPEAT_MAX:  cfg_r.repeat_max <= cfg_data[rtt_pkg::COUNT_W-1:0];
        rtt_pkg::CFG_EXTRA_FINAL: cfg_r.extra_final_period <= cfg_data[0];
        rtt_pkg::CFG_ONESHOT:     cfg_r.oneshot_mode <= cfg_data[rtt_pkg::OS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/rtt_in.sv =====
// ---------------------------------------------------------------------------
// Repeating task timer input register
// Holds one accepted item until the timer logic takes it.
// ---------------------------------------------------------------------------
module rtt_in (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_command,
  input  logic [rtt_pkg::TIME_W-1:0]  in_now,
  input  logic                        in_start_enable,
  input  logic                        take,
  output logic                        item_valid,
  output rtt_pkg::item_t              item
);

  logic           valid_r;
  logic           valid_nxt;
  rtt_pkg::item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.command      <= in_command;
      item_r.now          <= in_now;
      item_r.start_enable <= in_start_enable;
    end
  end

endmodule

// ===== src/rtt_core.sv =====
// ---------------------------------------------------------------------------
// Repeating task timer core
// Timer state and the single-pass update that turns one item into events.
// ---------------------------------------------------------------------------
module rtt_core (
  input  logic           clk,
  input  logic           rst_n,
  input  rtt_pkg::cfg_t  cfg,
  input  logic           take,
  input  rtt_pkg::item_t item,
  output rtt_pkg::res_t  res
);

  localparam int TW = rtt_pkg::TIME_W;
  localparam int CW = rtt_pkg::COUNT_W;

  logic          delay_armed_r, delay_armed_nxt;
  logic [TW-1:0] delay_mark_r, delay_mark_nxt;
  logic          timer_on_r, timer_on_nxt;
  logic [TW-1:0] timer_mark_r, timer_mark_nxt;
  logic          end_on_r, end_on_nxt;
  logic [TW-1:0] end_mark_r, end_mark_nxt;
  logic [CW-1:0] repeat_count_r, repeat_count_nxt;

  logic                                         delay_present;
  logic [TW-1:0]                                el_delay, el_end, el_timer;
  logic                                         do_start, st_en, finished;
  logic [rtt_pkg::RCNT_W-1:0]                   cnt;
  logic [rtt_pkg::NRES-1:0][rtt_pkg::EV_W-1:0]  evs;

  assign res.cnt = cnt;
  assign res.evs = evs;

  always_comb begin
    delay_armed_nxt  = delay_armed_r;
    delay_mark_nxt   = delay_mark_r;
    timer_on_nxt     = timer_on_r;
    timer_mark_nxt   = timer_mark_r;
    end_on_nxt       = end_on_r;
    end_mark_nxt     = end_mark_r;
    repeat_count_nxt = repeat_count_r;
    cnt              = '0;
    evs              = '0;
    do_start         = 1'b0;
    st_en            = 1'b0;
    finished         = 1'b0;
    el_end           = '0;
    el_timer         = '0;

    delay_present = (cfg.start_delay != '0) && delay_armed_r;
    el_delay      = item.now - delay_mark_r;

    if (!item.command) begin
      if (delay_present && (el_delay >= cfg.start_delay)) begin
        delay_mark_nxt  = item.now;
        delay_armed_nxt = 1'b0;
        do_start        = 1'b1;
        st_en           = 1'b1;
      end
    end else if (!delay_present) begin
      do_start = 1'b1;
      st_en    = item.start_enable;
    end

    if (do_start) begin
      if (cfg.repeat_max == '0) begin
        if (st_en) begin
          case (cfg.oneshot_mode)
            rtt_pkg::OS_S: begin
              evs[0] = rtt_pkg::EV_START;
              cnt    = 2'd1;
            end
            rtt_pkg::OS_C: begin
              evs[0] = rtt_pkg::EV_MAIN;
              cnt    = 2'd1;
            end
            rtt_pkg::OS_SC: begin
              evs[0] = rtt_pkg::EV_START;
              evs[1] = rtt_pkg::EV_MAIN;
              cnt    = 2'd2;
            end
            rtt_pkg::OS_SCE: begin
              evs[0] = rtt_pkg::EV_START;
              evs[1] = rtt_pkg::EV_MAIN;
              evs[2] = rtt_pkg::EV_END;
              cnt    = 2'd3;
            end
            rtt_pkg::OS_SE: begin
              evs[0] = rtt_pkg::EV_START;
              evs[1] = rtt_pkg::EV_END;
              cnt    = 2'd2;
            end
            rtt_pkg::OS_CE: begin
              evs[0] = rtt_pkg::EV_MAIN;
              evs[1] = rtt_pkg::EV_END;
              cnt    = 2'd2;
            end
            default: ;
          endcase
          timer_on_nxt = 1'b0;
        end
      end else begin
        evs[0]         = rtt_pkg::EV_START;
        cnt            = 2'd1;
        timer_on_nxt   = st_en;
        timer_mark_nxt = item.now;
        if (cfg.end_time != '0) begin
          end_on_nxt   = st_en;
          end_mark_nxt = item.now;
        end
      end
    end

    if (!item.command && timer_on_nxt) begin
      el_end = item.now - end_mark_nxt;
      if ((cfg.end_time != '0) && end_on_nxt && (el_end >= cfg.end_time)) begin
        end_mark_nxt = item.now;
        timer_on_nxt = 1'b0;
        end_on_nxt   = 1'b0;
        if (cnt != 2'd3) begin
          evs[cnt] = rtt_pkg::EV_END;
          cnt      = cnt + 2'd1;
        end
      end
      el_timer = item.now - timer_mark_nxt;
      if (timer_on_nxt && (el_timer >= cfg.period)) begin
        timer_mark_nxt = item.now;
        if (cfg.repeat_max == '0) begin
          if (cnt != 2'd3) begin
            evs[cnt] = rtt_pkg::EV_MAIN;
            cnt      = cnt + 2'd1;
          end
        end else begin
          repeat_count_nxt = repeat_count_nxt + CW'(1);
          finished = cfg.extra_final_period ? (repeat_count_nxt > cfg.repeat_max)
                                            : (repeat_count_nxt >= cfg.repeat_max);
          if (finished) begin
            repeat_count_nxt = '0;
            timer_on_nxt     = 1'b0;
            if (!cfg.extra_final_period && (cnt != 2'd3)) begin
              evs[cnt] = rtt_pkg::EV_MAIN;
              cnt      = cnt + 2'd1;
            end
            if (cnt != 2'd3) begin
              evs[cnt] = rtt_pkg::EV_END;
              cnt      = cnt + 2'd1;
            end
          end else if (cnt != 2'd3) begin
            evs[cnt] = rtt_pkg::EV_MAIN;
            cnt      = cnt + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_armed_r  <= 1'b1;
      delay_mark_r   <= '0;
      timer_on_r     <= 1'b1;
      timer_mark_r   <= '0;
      end_on_r       <= 1'b1;
      end_mark_r     <= '0;
      repeat_count_r <= '0;
    end else if (take) begin
      delay_armed_r  <= delay_armed_nxt;
      delay_mark_r   <= delay_mark_nxt;
      timer_on_r     <= timer_on_nxt;
      timer_mark_r   <= timer_mark_nxt;
      end_on_r       <= end_on_nxt;
      end_mark_r     <= end_mark_nxt;
      repeat_count_r <= repeat_count_nxt;
    end
  end

endmodule

// ===== src/rtt_out.sv =====
// ---------------------------------------------------------------------------
// Repeating task timer result register
// Holds the events of one item and hands them out one transfer at a time.
// ---------------------------------------------------------------------------
`include "repeating_task_timer_macros.svh"

module rtt_out (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  rtt_pkg::res_t                res,
  output logic                         free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rtt_pkg::EV_W-1:0]     out_event_res,
  output logic                         out_last
);

  logic                                         res_valid_r, res_valid_nxt;
  logic [rtt_pkg::RCNT_W-1:0]                   res_cnt_r;
  logic [rtt_pkg::NRES-1:0][rtt_pkg::EV_W-1:0]  res_evs_r;
  logic [rtt_pkg::RCNT_W-1:0]                   idx_r, idx_nxt;
  logic                                         xfer;

  assign out_valid     = res_valid_r;
  assign out_event_res = res_evs_r[idx_r];
  assign out_last      = (idx_r == (res_cnt_r - 2'd1));
  assign xfer          = res_valid_r && out_ready;
  assign free          = !res_valid_r || (xfer && out_last);

  always_comb begin
    res_valid_nxt = res_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      res_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (xfer) begin
      if (out_last) begin
        res_valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      res_valid_r <= res_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_cnt_r <= res.cnt;
      res_evs_r <= res.evs;
    end
  end

  `RTT_ASSERT(a_cnt_nonzero, res_valid_r |-> (res_cnt_r != 2'd0), "held result has no events")
  `RTT_ASSERT(a_idx_in_range, res_valid_r |-> (idx_r < res_cnt_r), "event index past count")
  `RTT_ASSERT(a_drain, (xfer && out_last && !load) |=> !res_valid_r, "result kept after last")
  `RTT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !res_valid_r, "result valid after reset")

endmodule

// ===== src/repeating_task_timer.sv =====
// An accepted item waits in the input register, its events in the result
// register. Throughput: one item per cycle while each item yields at most
// one event and out_ready is high; an item with k events holds the result
// register for k output transfers. Items that yield no event load nothing.
// Reset: synchronous, active low; resets valid flags, config and timer state.
// ---------------------------------------------------------------------------
// Repeating task timer
// Tick and start items drive start, periodic main and end events.
// ---------------------------------------------------------------------------
module repeating_task_timer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_command,
  input  logic [rtt_pkg::TIME_W-1:0]       in_now,
  input  logic                             in_start_enable,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rtt_pkg::EV_W-1:0]         out_event_res,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rtt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rtt_pkg::cfg_t  cfg;
  rtt_pkg::item_t item;
  rtt_pkg::res_t  res;
  logic           item_valid;
  logic           free;
  logic           take;
  logic           load;

  assign take = item_valid && free;
  assign load = take && (res.cnt != 2'd0);

  rtt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rtt_in u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_now          (in_now),
    .in_start_enable (in_start_enable),
    .take            (take),
    .item_valid      (item_valid),
    .item            (item)
  );

  rtt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .take  (take),
    .item  (item),
    .res   (res)
  );

  rtt_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .res           (res),
    .free          (free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_event_res (out_event_res),
    .out_last      (out_last)
  );

endmodule
